[src/bitmap_page_run_allocator_defines.svh]
//------------------------------------------------------------------------------
// Assertion macros for the bitmap page run allocator
// Clocked on clk, disabled while arst_n is low.
//------------------------------------------------------------------------------
`ifndef BITMAP_PAGE_RUN_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_RUN_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BPRA_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bpra assertion failed");
`define BPRA_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("bpra forbidden condition");
`else
`define BPRA_ASSERT(label, prop)
`define BPRA_NEVER(label, expr)
`endif
`endif

[src/bpra_pkg.sv]
//------------------------------------------------------------------------------
// bpra_pkg
// Shared types, codes and defaults of the bitmap page run allocator.
//------------------------------------------------------------------------------
package bpra_pkg;

	localparam int MAX_PAGES_DEF = 1024;
	localparam int WORD_BITS_DEF = 64;

	localparam int CNT_W  = 11;
	localparam int PAGE_W = 10;

	typedef enum logic [1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_INIT  = 2'd2,
		KIND_QUERY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOMEM   = 2'd1,
		ST_INVALID = 2'd2,
		ST_STATE   = 2'd3
	} status_t;

	localparam logic [2:0] ADDR_REGION   = 3'd0;
	localparam logic [2:0] ADDR_RESERVED = 3'd4;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_DECODE,
		FSM_SCAN,
		FSM_CHECK,
		FSM_WRITE,
		FSM_QUERY,
		FSM_DONE
	} fsm_t;

	typedef struct packed {
		logic    load;
		logic    prep;
		logic    clear;
		logic    scan;
		logic    check;
		logic    write;
		logic    wval;
		logic    query;
		logic    finish;
		status_t status;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  n_zero;
		logic  n_over;
		logic  free_bad;
		logic  init_bad;
		logic  at_end;
		logic  hit;
		logic  bit_free;
		logic  cnt_last;
	} stat_t;

endpackage

[src/bpra_ctrl.sv]
//------------------------------------------------------------------------------
// bpra_ctrl
// Command sequencer: decodes a request and steps the datapath to completion.
//------------------------------------------------------------------------------
module bpra_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bpra_pkg::stat_t stat,
	output bpra_pkg::cmd_t  cmd
);
	import bpra_pkg::*;

	fsm_t    state_q, state_d;
	status_t status_q, status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FSM_IDLE;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		case (state_q)
			FSM_IDLE: begin
				status_d = ST_OK;
				if (start) state_d = FSM_DECODE;
			end
			FSM_DECODE: begin
				case (stat.kind)
					KIND_ALLOC: begin
						if (stat.n_zero) begin
							status_d = ST_INVALID;
							state_d  = FSM_DONE;
						end else if (stat.n_over) begin
							status_d = ST_NOMEM;
							state_d  = FSM_DONE;
						end else state_d = FSM_SCAN;
					end
					KIND_FREE: begin
						if (stat.free_bad) begin
							status_d = ST_INVALID;
							state_d  = FSM_DONE;
						end else state_d = FSM_CHECK;
					end
					KIND_INIT: begin
						if (stat.init_bad) begin
							status_d = ST_NOMEM;
							state_d  = FSM_DONE;
						end else state_d = FSM_WRITE;
					end
					default: state_d = FSM_QUERY;
				endcase
			end
			FSM_SCAN: begin
				if (stat.at_end) begin
					status_d = ST_NOMEM;
					state_d  = FSM_DONE;
				end else if (stat.hit) state_d = FSM_WRITE;
			end
			FSM_CHECK: begin
				if (stat.bit_free) begin
					status_d = ST_STATE;
					state_d  = FSM_DONE;
				end else if (stat.cnt_last) state_d = FSM_WRITE;
			end
			FSM_WRITE: begin
				if (stat.cnt_last) state_d = FSM_DONE;
			end
			FSM_QUERY: begin
				if (stat.at_end) state_d = FSM_DONE;
			end
			FSM_DONE: state_d = FSM_IDLE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.status = status_q;
		cmd.wval   = (stat.kind != KIND_ALLOC);
		case (state_q)
			FSM_IDLE:   cmd.load = start;
			FSM_DECODE: begin
				cmd.prep  = 1'b1;
				cmd.clear = (stat.kind == KIND_INIT) && !stat.init_bad;
			end
			FSM_SCAN:   cmd.scan = !stat.at_end;
			FSM_CHECK: begin
				if (!stat.bit_free) begin
					if (stat.cnt_last) cmd.prep = 1'b1;
					else cmd.check = 1'b1;
				end
			end
			FSM_WRITE:  cmd.write = 1'b1;
			FSM_QUERY:  cmd.query = !stat.at_end;
			FSM_DONE:   cmd.finish = 1'b1;
			default:    cmd.finish = 1'b0;
		endcase
	end

	assign busy = (state_q != FSM_IDLE);

endmodule

[src/bpra_dpath.sv]
//------------------------------------------------------------------------------
// bpra_dpath
// Free-page bitmap, page cursor and counters, result registers.
//------------------------------------------------------------------------------
module bpra_dpath #(
	parameter int MAX_PAGES = bpra_pkg::MAX_PAGES_DEF,
	parameter int WORD_BITS = bpra_pkg::WORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bpra_pkg::cmd_t             cmd,
	output bpra_pkg::stat_t            stat,
	input  logic [1:0]                 kind,
	input  logic [bpra_pkg::CNT_W-1:0]  page_count,
	input  logic [bpra_pkg::PAGE_W-1:0] page_index,
	input  logic [bpra_pkg::CNT_W-1:0]  region_pages,
	input  logic [bpra_pkg::PAGE_W-1:0] reserved_pages,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [bpra_pkg::PAGE_W-1:0] start_page,
	output logic [bpra_pkg::CNT_W-1:0]  largest_free_run,
	output logic                       heap_busy,
	output logic [bpra_pkg::CNT_W-1:0]  allocated_pages
);
	import bpra_pkg::*;

	localparam int WBB = $clog2(WORD_BITS);
	localparam int NW  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WIW = (NW > 1) ? $clog2(NW) : 1;
	localparam int PCW = $clog2(MAX_PAGES + 1);
	localparam int CW  = (PCW > CNT_W) ? PCW : CNT_W;

	logic [WORD_BITS-1:0] map_q [NW];
	kind_t               kind_q;
	logic [CW-1:0]       n_q, idx_q, p_q, cnt_q, run_q, first_q, largest_q;
	logic                busy_q;
	logic [CNT_W-1:0]    used_q;

	logic [CW-1:0]        rp, rs, run_inc, first_sel, p_skip;
	logic [CW:0]          free_end;
	logic [WIW-1:0]       wi;
	logic [WBB-1:0]       bi;
	logic [WORD_BITS-1:0] cur_word;
	logic                 bit_free, wf;

	assign rp = (CW'(region_pages) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(region_pages);
	assign rs = (CW'(reserved_pages) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES)
		: CW'(reserved_pages);

	assign wi       = p_q[WBB +: WIW];
	assign bi       = p_q[WBB-1:0];
	assign cur_word = map_q[wi];
	assign bit_free = cur_word[bi];
	assign wf       = |cur_word;
	assign run_inc  = run_q + CW'(1);
	assign first_sel = (run_q == '0) ? p_q : first_q;
	assign p_skip   = (p_q | CW'(WORD_BITS - 1)) + CW'(1);
	assign free_end = {1'b0, idx_q} + {1'b0, n_q};

	always_comb begin
		stat.kind     = kind_q;
		stat.n_zero   = (n_q == '0);
		stat.n_over   = (n_q > rp);
		stat.free_bad = (n_q == '0) || (free_end > {1'b0, rp}) || (idx_q < rs);
		stat.init_bad = (rs >= rp);
		stat.at_end   = (p_q >= rp);
		stat.hit      = wf && bit_free && (run_inc == n_q);
		stat.bit_free = bit_free;
		stat.cnt_last = (cnt_q == CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NW; i++) map_q[i] <= '0;
			used_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cmd.clear) begin
				for (int i = 0; i < NW; i++) map_q[i] <= '0;
			end
			if (cmd.write) begin
				map_q[wi][bi] <= cmd.wval;
				if (cnt_q == CW'(1)) begin
					case (kind_q)
						KIND_ALLOC: used_q <= used_q + CNT_W'(n_q);
						KIND_FREE:  used_q <= (used_q > CNT_W'(n_q))
							? used_q - CNT_W'(n_q) : '0;
						default:    used_q <= '0;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_t'(kind);
			n_q    <= CW'(page_count);
			idx_q  <= CW'(page_index);
		end
		if (cmd.prep) begin
			run_q     <= '0;
			largest_q <= '0;
			busy_q    <= 1'b0;
			case (kind_q)
				KIND_FREE: begin
					p_q   <= idx_q;
					cnt_q <= n_q;
				end
				KIND_INIT: begin
					p_q   <= rs;
					cnt_q <= rp - rs;
				end
				default: begin
					p_q   <= '0;
					cnt_q <= n_q;
				end
			endcase
		end
		if (cmd.scan) begin
			if (!wf) begin
				run_q <= '0;
				p_q   <= p_skip;
			end else if (bit_free) begin
				if (run_inc == n_q) begin
					p_q     <= first_sel;
					cnt_q   <= n_q;
					first_q <= first_sel;
				end else begin
					first_q <= first_sel;
					run_q   <= run_inc;
					p_q     <= p_q + CW'(1);
				end
			end else begin
				run_q <= '0;
				p_q   <= p_q + CW'(1);
			end
		end
		if (cmd.check || cmd.write) begin
			p_q   <= p_q + CW'(1);
			cnt_q <= cnt_q - CW'(1);
		end
		if (cmd.query) begin
			p_q <= p_q + CW'(1);
			if (bit_free) begin
				run_q <= run_inc;
				if (run_inc > largest_q) largest_q <= run_inc;
			end else begin
				run_q <= '0;
				if (p_q >= rs) busy_q <= 1'b1;
			end
		end
		if (cmd.finish) begin
			status           <= cmd.status;
			start_page       <= (kind_q == KIND_ALLOC && cmd.status == ST_OK)
				? PAGE_W'(first_q) : '0;
			largest_free_run <= (kind_q == KIND_QUERY) ? CNT_W'(largest_q) : '0;
			heap_busy        <= (kind_q == KIND_QUERY) ? busy_q : 1'b0;
			allocated_pages  <= used_q;
		end
	end

endmodule

[src/bitmap_page_run_allocator.sv]
//------------------------------------------------------------------------------
// bitmap_page_run_allocator
// First-fit page run allocator over a free-page bitmap, with APB registers.
//------------------------------------------------------------------------------
// Request flow: decode, work, done. Alloc visits pages in order (an empty word is
// skipped whole) then writes N pages; free checks N pages then writes them; init
// writes each usable page; query visits every region page.
// One request at a time; busy drops as done rises, so the next request can be
// taken in the done cycle. done pulses for one cycle; the receiver cannot stall.
// Reset: bitmap all taken, no pages in use, region 1024, reserved 1.
module bitmap_page_run_allocator #(
	parameter int MAX_PAGES = bpra_pkg::MAX_PAGES_DEF,
	parameter int WORD_BITS = bpra_pkg::WORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 kind,
	input  logic [bpra_pkg::CNT_W-1:0]  page_count,
	input  logic [bpra_pkg::PAGE_W-1:0] page_index,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [bpra_pkg::PAGE_W-1:0] start_page,
	output logic [bpra_pkg::CNT_W-1:0]  largest_free_run,
	output logic                       heap_busy,
	output logic [bpra_pkg::CNT_W-1:0]  allocated_pages
);
	import bpra_pkg::*;
	`include "bitmap_page_run_allocator_defines.svh"

	logic [CNT_W-1:0]  region_q;
	logic [PAGE_W-1:0] reserved_q;
	logic              wr_en;
	cmd_t              cmd;
	stat_t             stat;

	// register file: writes land in the access phase
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q   <= CNT_W'(1024);
			reserved_q <= PAGE_W'(1);
		end else if (wr_en) begin
			if (paddr == ADDR_REGION) region_q <= pwdata[CNT_W-1:0];
			else if (paddr == ADDR_RESERVED) reserved_q <= pwdata[PAGE_W-1:0];
		end
	end

	always_comb begin
		case (paddr)
			ADDR_REGION:   prdata = 32'(region_q);
			ADDR_RESERVED: prdata = 32'(reserved_q);
			default:       prdata = '0;
		endcase
	end

	bpra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	bpra_dpath #(
		.MAX_PAGES (MAX_PAGES),
		.WORD_BITS (WORD_BITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.kind             (kind),
		.page_count       (page_count),
		.page_index       (page_index),
		.region_pages     (region_q),
		.reserved_pages   (reserved_q),
		.done             (done),
		.status           (status),
		.start_page       (start_page),
		.largest_free_run (largest_free_run),
		.heap_busy        (heap_busy),
		.allocated_pages  (allocated_pages)
	);

	// a result never follows itself; an accepted request always goes busy
	`BPRA_ASSERT(a_done_single, done |=> !done)
	`BPRA_ASSERT(a_start_busy, (start && !busy) |=> busy)
	`BPRA_NEVER(a_done_while_busy_start, done && $past(start && !busy))

endmodule
